### hw/rtl/ksl_pkg.sv
`default_nettype none

package ksl_pkg;

   localparam int MAX_FRAMES  = 64;
   localparam int MAX_SAMPLES = 1024;
   localparam int KEY_AW      = $clog2(MAX_FRAMES);
   localparam int TAB_AW      = $clog2(MAX_SAMPLES);
   localparam int CNT_W       = TAB_AW + 1;
   localparam int TIME_W      = 32;
   localparam int SEG_W       = 6;
   localparam int FC_W        = 7;
   localparam int SPS_W       = 8;
   localparam int CSR_DATA_W  = 8;
   localparam int CSR_IDX_W   = 1;
   localparam int NS_W        = TIME_W + SPS_W - 16;
   localparam int DVS_W       = TIME_W;
   localparam int DIV_W       = TIME_W + NS_W + 1;
   localparam int DIV_CNT_W   = $clog2(DIV_W);

   localparam logic [FC_W-1:0]  FC_MAX    = FC_W'(MAX_FRAMES);
   localparam logic [SPS_W-1:0] SPS_RESET = SPS_W'(30);

   localparam logic [1:0] OP_LOAD    = 2'd0;
   localparam logic [1:0] OP_REBUILD = 2'd1;
   localparam logic [1:0] OP_QUERY   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPS         = 1'b1;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DISPATCH,
      S_RD_LAST,
      S_RD_PEN,
      S_GET_PEN,
      S_NS,
      S_BRANCH,
      S_REB_MUL,
      S_REB_DIV_GO,
      S_REB_DIV_WAIT,
      S_WALK_RD,
      S_WALK_CMP,
      S_LOOP_DIV_GO,
      S_LOOP_DIV_WAIT,
      S_Q_MUL,
      S_Q_DIV_GO,
      S_Q_DIV_WAIT,
      S_TAB_GET,
      S_DONE
   } state_type;

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_CAPTURE,
      CMD_KEY_WRITE,
      CMD_RD_FIRST,
      CMD_RD_LAST,
      CMD_RD_PEN,
      CMD_GET_PEN,
      CMD_NS,
      CMD_REB_INIT,
      CMD_REB_MUL,
      CMD_REB_T,
      CMD_WALK_RD,
      CMD_WALK_CMP,
      CMD_LOOP_SETUP,
      CMD_OFF_WRAP,
      CMD_OFF_DIRECT,
      CMD_Q_MUL,
      CMD_SET_FAIL,
      CMD_SET_SEG_PEN,
      CMD_TAB_READ,
      CMD_SET_SEG_TAB
   } dp_cmd_type;

   typedef struct packed {
      dp_cmd_type op;
      logic       div_start;
      logic       rsp_valid;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       looping;
      logic       n_small;
      logic       ns_small;
      logic       dur_pos;
      logic       le_start;
      logic       ge_pen;
      logic       walk_done;
      logic       last_sample;
      logic       div_done;
      logic       pos_bad;
   } dp_status_type;

endpackage

`default_nettype wire

### hw/rtl/ksl_ram.sv
`default_nettype none

module ksl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/ksl_div.sv
`default_nettype none

module ksl_div import ksl_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DIV_W-1:0] dividend,
   input  wire logic [DVS_W-1:0] divisor,
   output logic      [DIV_W-1:0] quotient,
   output logic      [DVS_W-1:0] remainder,
   output logic                  done
);

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_W-1:0]     quo_ff;
   logic [DVS_W-1:0]     rem_ff;
   logic [DVS_W:0]       trial;
   logic [DVS_W:0]       diff;
   logic                 fits;

   // one quotient bit per cycle, restoring
   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign fits  = trial >= {1'b0, divisor};
   assign diff  = trial - {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         cnt_ff <= DIV_CNT_W'(DIV_W - 1);
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         quo_ff <= {quo_ff[DIV_W-2:0], fits};
         cnt_ff <= cnt_ff - DIV_CNT_W'(1);
      end
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

`default_nettype wire

### hw/rtl/ksl_datapath.sv
`default_nettype none

module ksl_datapath import ksl_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ctrl_cmd_type          cmd,
   output dp_status_type              status,
   input  wire logic [1:0]            req_op,
   input  wire logic [KEY_AW-1:0]     req_key_index,
   input  wire logic [TIME_W-1:0]     req_key_time,
   input  wire logic [TIME_W-1:0]     req_query_time,
   input  wire logic                  req_looping,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data,
   output logic                       rsp_status,
   output logic      [SEG_W-1:0]      rsp_segment_index
);

   logic [FC_W-1:0]          frame_count_ff;
   logic [SPS_W-1:0]         sps_ff;
   logic [CNT_W-1:0]         sample_count_ff;

   logic [1:0]               op_ff;
   logic [KEY_AW-1:0]        key_index_ff;
   logic [TIME_W-1:0]        key_time_ff;
   logic signed [TIME_W-1:0] qt_ff;
   logic                     loop_ff;
   logic signed [TIME_W-1:0] start_ff;
   logic signed [TIME_W-1:0] end_ff;
   logic signed [TIME_W-1:0] pen_ff;
   logic signed [TIME_W:0]   dur_ff;
   logic [NS_W-1:0]          ns_ff;
   logic [TAB_AW-1:0]        i_ff;
   logic [KEY_AW-1:0]        j_ff;
   logic signed [TIME_W:0]   t_ff;
   logic                     xneg_ff;
   logic [TIME_W-1:0]        off_ff;
   logic [DIV_W-1:0]         prod_ff;
   logic [DVS_W-1:0]         dvs_ff;
   logic                     status_ff;
   logic [SEG_W-1:0]         seg_ff;

   logic [FC_W-1:0]          n;
   logic [FC_W-1:0]          n_m1;
   logic [FC_W-1:0]          n_m2;
   logic [CNT_W-1:0]         ns_sat;
   logic                     ns_small;
   logic                     dur_pos;
   logic signed [TIME_W:0]   x;
   logic [TIME_W:0]          x_neg;
   logic [TIME_W-1:0]        abs_x;
   logic [TIME_W+SPS_W-1:0]  ns_prod;
   logic [TAB_AW+TIME_W-1:0] reb_prod;
   logic [TIME_W+NS_W-1:0]   q_prod;
   logic [TIME_W-1:0]        key_rdata;
   logic [SEG_W-1:0]         tab_rdata;
   logic                     key_hit;
   logic                     walk_done;
   logic [SEG_W-1:0]         walk_idx;
   logic [KEY_AW-1:0]        key_raddr;
   logic [DIV_W-1:0]         quo;
   logic [DVS_W-1:0]         rem;
   logic                     div_done;
   logic [TIME_W-1:0]        wrap_off;

   assign n        = (frame_count_ff > FC_MAX) ? FC_MAX : frame_count_ff;
   assign n_m1     = n - FC_W'(1);
   assign n_m2     = n - FC_W'(2);
   assign ns_sat   = (ns_ff > NS_W'(MAX_SAMPLES)) ? CNT_W'(MAX_SAMPLES) : ns_ff[CNT_W-1:0];
   assign ns_small = ns_sat < CNT_W'(2);
   assign dur_pos  = !dur_ff[TIME_W] && (dur_ff != '0);
   assign x        = {qt_ff[TIME_W-1], qt_ff} - {start_ff[TIME_W-1], start_ff};
   assign x_neg    = -x;
   assign abs_x    = x[TIME_W] ? x_neg[TIME_W-1:0] : x[TIME_W-1:0];
   assign ns_prod  = dur_ff[TIME_W-1:0] * sps_ff;
   assign reb_prod = i_ff * dur_ff[TIME_W-1:0];
   assign q_prod   = off_ff * ns_ff;
   assign key_hit  = t_ff >= $signed({key_rdata[TIME_W-1], key_rdata});
   assign walk_done = key_hit || (j_ff == '0);
   assign walk_idx = !key_hit ? '0 :
                     ({1'b0, j_ff} > n_m2) ? n_m2[SEG_W-1:0] : j_ff;
   assign wrap_off = (xneg_ff && rem != '0) ? dur_ff[TIME_W-1:0] - rem : rem;

   always_comb begin
      unique case (cmd.op)
         CMD_RD_FIRST: key_raddr = '0;
         CMD_RD_LAST:  key_raddr = n_m1[KEY_AW-1:0];
         CMD_RD_PEN:   key_raddr = n_m2[KEY_AW-1:0];
         default:      key_raddr = j_ff;
      endcase
   end

   ksl_ram #(.WIDTH(TIME_W), .DEPTH(MAX_FRAMES)) u_key_ram (
      .clock   (clock),
      .wr_en   (cmd.op == CMD_KEY_WRITE),
      .wr_addr (key_index_ff),
      .wr_data (key_time_ff),
      .rd_addr (key_raddr),
      .rd_data (key_rdata)
   );

   ksl_ram #(.WIDTH(SEG_W), .DEPTH(MAX_SAMPLES)) u_tab_ram (
      .clock   (clock),
      .wr_en   (cmd.op == CMD_WALK_CMP && walk_done),
      .wr_addr (i_ff),
      .wr_data (walk_idx),
      .rd_addr (quo[TAB_AW-1:0]),
      .rd_data (tab_rdata)
   );

   ksl_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (prod_ff),
      .divisor   (dvs_ff),
      .quotient  (quo),
      .remainder (rem),
      .done      (div_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff  <= '0;
         sps_ff          <= SPS_RESET;
         sample_count_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_FRAME_COUNT: frame_count_ff <= csr_write_data[FC_W-1:0];
               CSR_SPS:         sps_ff         <= csr_write_data;
               default:         ;
            endcase
         end
         if (cmd.op == CMD_REB_INIT) begin
            sample_count_ff <= ns_small ? '0 : ns_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         CMD_CAPTURE: begin
            op_ff        <= req_op;
            key_index_ff <= req_key_index;
            key_time_ff  <= req_key_time;
            qt_ff        <= req_query_time;
            loop_ff      <= req_looping;
            status_ff    <= 1'b0;
            seg_ff       <= '0;
         end
         CMD_RD_LAST: start_ff <= key_rdata;
         CMD_RD_PEN:  end_ff   <= key_rdata;
         CMD_GET_PEN: begin
            pen_ff <= key_rdata;
            dur_ff <= {end_ff[TIME_W-1], end_ff} - {start_ff[TIME_W-1], start_ff};
         end
         CMD_NS:       ns_ff <= dur_pos ? ns_prod[TIME_W+SPS_W-1:16] : '0;
         CMD_REB_INIT: i_ff  <= '0;
         CMD_REB_MUL: begin
            prod_ff <= DIV_W'(reb_prod);
            dvs_ff  <= DVS_W'(ns_sat - CNT_W'(1));
         end
         CMD_REB_T: begin
            t_ff <= {start_ff[TIME_W-1], start_ff} + {1'b0, quo[TIME_W-1:0]};
            j_ff <= n_m1[KEY_AW-1:0];
         end
         CMD_WALK_CMP: begin
            if (walk_done) begin
               i_ff <= i_ff + TAB_AW'(1);
            end else begin
               j_ff <= j_ff - KEY_AW'(1);
            end
         end
         CMD_LOOP_SETUP: begin
            prod_ff <= DIV_W'(abs_x);
            dvs_ff  <= dur_ff[TIME_W-1:0];
            xneg_ff <= x[TIME_W];
         end
         CMD_OFF_WRAP:   off_ff <= wrap_off;
         CMD_OFF_DIRECT: off_ff <= x[TIME_W-1:0];
         CMD_Q_MUL: begin
            prod_ff <= DIV_W'(q_prod);
            dvs_ff  <= dur_ff[TIME_W-1:0];
         end
         CMD_SET_FAIL: begin
            status_ff <= 1'b1;
            seg_ff    <= '0;
         end
         CMD_SET_SEG_PEN: seg_ff <= n_m2[SEG_W-1:0];
         CMD_SET_SEG_TAB: seg_ff <= tab_rdata;
         default: ;
      endcase
   end

   always_comb begin
      status.op          = op_ff;
      status.looping     = loop_ff;
      status.n_small     = n < FC_W'(2);
      status.ns_small    = ns_small;
      status.dur_pos     = dur_pos;
      status.le_start    = qt_ff <= start_ff;
      status.ge_pen      = qt_ff >= pen_ff;
      status.walk_done   = walk_done;
      status.last_sample = {1'b0, i_ff} == (sample_count_ff - CNT_W'(1));
      status.div_done    = div_done;
      status.pos_bad     = quo >= DIV_W'(sample_count_ff);
   end

   assign rsp_status        = status_ff;
   assign rsp_segment_index = seg_ff;

endmodule

`default_nettype wire

### hw/rtl/ksl_ctrl.sv
`default_nettype none

module ksl_ctrl import ksl_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd,
   output logic               busy
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd.op        = CMD_NONE;
      cmd.div_start = 1'b0;
      cmd.rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op   = CMD_CAPTURE;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_DONE;
            case (status.op) inside
               OP_LOAD: cmd.op = CMD_KEY_WRITE;
               OP_REBUILD, OP_QUERY: begin
                  if (status.n_small) begin
                     if (status.op == OP_QUERY) begin
                        cmd.op = CMD_SET_FAIL;
                     end
                  end else begin
                     cmd.op   = CMD_RD_FIRST;
                     state_in = S_RD_LAST;
                  end
               end
               default: ;
            endcase
         end
         S_RD_LAST: begin
            cmd.op   = CMD_RD_LAST;
            state_in = S_RD_PEN;
         end
         S_RD_PEN: begin
            cmd.op   = CMD_RD_PEN;
            state_in = S_GET_PEN;
         end
         S_GET_PEN: begin
            cmd.op   = CMD_GET_PEN;
            state_in = S_NS;
         end
         S_NS: begin
            cmd.op   = CMD_NS;
            state_in = S_BRANCH;
         end
         S_BRANCH: begin
            state_in = S_DONE;
            if (status.op == OP_REBUILD) begin
               cmd.op = CMD_REB_INIT;
               if (!status.ns_small) begin
                  state_in = S_REB_MUL;
               end
            end else if (status.looping) begin
               if (status.dur_pos) begin
                  cmd.op   = CMD_LOOP_SETUP;
                  state_in = S_LOOP_DIV_GO;
               end else begin
                  cmd.op = CMD_SET_FAIL;
               end
            end else if (status.le_start) begin
               cmd.op = CMD_NONE;
            end else if (status.ge_pen) begin
               cmd.op = CMD_SET_SEG_PEN;
            end else if (!status.dur_pos) begin
               cmd.op = CMD_SET_FAIL;
            end else begin
               cmd.op   = CMD_OFF_DIRECT;
               state_in = S_Q_MUL;
            end
         end
         S_REB_MUL: begin
            cmd.op   = CMD_REB_MUL;
            state_in = S_REB_DIV_GO;
         end
         S_REB_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = S_REB_DIV_WAIT;
         end
         S_REB_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.op   = CMD_REB_T;
               state_in = S_WALK_RD;
            end
         end
         S_WALK_RD: begin
            cmd.op   = CMD_WALK_RD;
            state_in = S_WALK_CMP;
         end
         S_WALK_CMP: begin
            cmd.op = CMD_WALK_CMP;
            if (!status.walk_done) begin
               state_in = S_WALK_RD;
            end else if (status.last_sample) begin
               state_in = S_DONE;
            end else begin
               state_in = S_REB_MUL;
            end
         end
         S_LOOP_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = S_LOOP_DIV_WAIT;
         end
         S_LOOP_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.op   = CMD_OFF_WRAP;
               state_in = S_Q_MUL;
            end
         end
         S_Q_MUL: begin
            cmd.op   = CMD_Q_MUL;
            state_in = S_Q_DIV_GO;
         end
         S_Q_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = S_Q_DIV_WAIT;
         end
         S_Q_DIV_WAIT: begin
            if (status.div_done) begin
               if (status.pos_bad) begin
                  cmd.op   = CMD_SET_FAIL;
                  state_in = S_DONE;
               end else begin
                  cmd.op   = CMD_TAB_READ;
                  state_in = S_TAB_GET;
               end
            end
         end
         S_TAB_GET: begin
            cmd.op   = CMD_SET_SEG_TAB;
            state_in = S_DONE;
         end
         S_DONE: begin
            cmd.rsp_valid = 1'b1;
            state_in      = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = state_ff != S_IDLE;

`ifndef SYNTH
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_valid |=> !cmd.rsp_valid)
      else $error("response strobe longer than one cycle");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_valid |=> !busy)
      else $error("controller not idle after response");

   a_div_free: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> !cmd.div_start && !status.div_done)
      else $error("divider restarted or finished too early");
`endif

endmodule

`default_nettype wire

### hw/rtl/keyframe_segment_lookup_top.sv
// Keyframe segment lookup.
// Items are offered on start with the req_ fields; one is taken at a clock
// edge where start is high and busy is low. busy stays high until the item's
// single result has been shown on rsp_status and rsp_segment_index for one
// cycle with rsp_valid high; the receiver cannot hold it off.
// Op load writes a key time in the dispatch state, then gives its result.
// Op rebuild fills the sample table: after setup, each sample takes a pass
// of the shift/subtract divider and a key walk that reads and then compares
// one key at a time through the registered key memory. A query that reads
// the table takes one divider pass, two when looping.
// The next item can be taken in the cycle after the result.
// Registers are written through csr_write_enable, csr_index and
// csr_write_data: index 0 frame_count, index 1 sample rate. The user must
// write them only while busy is low; the block does not enforce it. Reset
// clears the controller, frame_count, the table fill count, and sets the
// sample rate to 30; key times and table entries are undefined until written.
`default_nettype none

module keyframe_segment_lookup_top import ksl_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [1:0]            req_op,
   input  wire logic [KEY_AW-1:0]     req_key_index,
   input  wire logic [TIME_W-1:0]     req_key_time,
   input  wire logic [TIME_W-1:0]     req_query_time,
   input  wire logic                  req_looping,
   output logic                       rsp_valid,
   output logic                       rsp_status,
   output logic      [SEG_W-1:0]      rsp_segment_index,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   ksl_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   ksl_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_op            (req_op),
      .req_key_index     (req_key_index),
      .req_key_time      (req_key_time),
      .req_query_time    (req_query_time),
      .req_looping       (req_looping),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .rsp_status        (rsp_status),
      .rsp_segment_index (rsp_segment_index)
   );

   assign rsp_valid = cmd.rsp_valid;

endmodule

`default_nettype wire
